// ===== src/dwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Delimited word tokenizer package
// Shared widths, register indexes and character constants.
// ----------------------------------------------------------------------------
package dwt_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CHAR_W      = 8;
   localparam int COUNT_W     = 16;
   localparam int DELIM_REGS  = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_DELIM_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DELIM_A      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_INDEX = 3'd5;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

endpackage

// ===== src/dwt_req_if.sv =====
// ----------------------------------------------------------------------------
// Tokenizer input channel
// One character item per handshake with end-of-string marker.
// ----------------------------------------------------------------------------
interface dwt_req_if;
   logic                       valid;
   logic                       ready;
   logic [dwt_pkg::CHAR_W-1:0] char_byte;
   logic                       byte_valid;
   logic                       string_end;

   modport source (output valid, output char_byte, output byte_valid,
                   output string_end, input ready);
   modport sink   (input valid, input char_byte, input byte_valid,
                   input string_end, output ready);
endinterface

// ===== src/dwt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Tokenizer result channel
// One result item per string.
// ----------------------------------------------------------------------------
interface dwt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dwt_pkg::COUNT_W-1:0] word_total;
   logic                        target_present;
   logic [dwt_pkg::COUNT_W-1:0] target_start;
   logic [dwt_pkg::COUNT_W-1:0] target_length;
   logic [dwt_pkg::COUNT_W-1:0] final_start;
   logic [dwt_pkg::COUNT_W-1:0] final_length;

   modport source (output valid, output word_total, output target_present,
                   output target_start, output target_length,
                   output final_start, output final_length, input ready);
   modport sink   (input valid, input word_total, input target_present,
                   input target_start, input target_length,
                   input final_start, input final_length, output ready);
endinterface

// ===== src/dwt_csr_if.sv =====
// ----------------------------------------------------------------------------
// Tokenizer configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface dwt_csr_if;
   logic                            valid;
   logic                            ready;
   logic [dwt_pkg::CSR_INDEX_W-1:0] index;
   logic [dwt_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/dwt_delim_match.sv =====
// ----------------------------------------------------------------------------
// Delimiter match
// Compares one character against the active delimiter registers, or against space when the delimiter count is zero.
// ----------------------------------------------------------------------------
module dwt_delim_match #(
   parameter int NUM_REGS = 4
) (
   input  logic [dwt_pkg::CHAR_W-1:0] char_byte,
   input  logic [2:0]                 delim_count,
   input  logic [dwt_pkg::CHAR_W-1:0] delims [NUM_REGS],
   output logic                       is_delim
);

   always_comb begin
      is_delim = 1'b0;
      if (delim_count == 3'd0) begin
         is_delim = (char_byte == dwt_pkg::SPACE_CHAR);
      end else begin
         for (int i = 0; i < NUM_REGS; i++) begin
            if ((3'(i) < delim_count) && (delims[i] == char_byte)) begin
               is_delim = 1'b1;
            end
         end
      end
   end

endmodule

// ===== src/delimited_word_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Delimited word tokenizer
// Counts words in a byte stream and reports the selected and the last word.
// ----------------------------------------------------------------------------
// A string enters on req_ch one byte per item; the item with string_end set
// closes the string (its byte, if byte_valid, is the last character). One
// result item leaves on rsp_ch per string: word count, the target word's
// start and length, and the last word's start and length (1-based).
// Delimiters and the target word number are set on csr_ch, which is always
// ready; write them only while no string is in flight.
// A closing item is registered in the input register, then evaluated; its
// result is loaded into the result register. Throughput: one item per cycle
// unless a closing item waits on rsp_ch; the per-string counters update per item.
// When rsp_ch stalls, bytes inside a string keep flowing; the next closing
// item waits in the input register until the pending result is taken.
// Reset clears all string state and the result valid flag, sets the delimiter
// count to zero (space only), delimiters to space and the target word to one.
// ----------------------------------------------------------------------------
module delimited_word_tokenizer #(
   parameter int unsigned MAX_CHARS   = 65535,
   parameter int          DELIM_SLOTS = 4
) (
   input  logic       clock,
   input  logic       reset,
   dwt_req_if.sink    req_ch,
   dwt_rsp_if.source  rsp_ch,
   dwt_csr_if.sink    csr_ch
);

   localparam int NREG = (DELIM_SLOTS < dwt_pkg::DELIM_REGS) ? DELIM_SLOTS
                                                               : dwt_pkg::DELIM_REGS;
   localparam logic [dwt_pkg::COUNT_W-1:0] SAT_LIMIT =
      (MAX_CHARS < 32'd65535) ? dwt_pkg::COUNT_W'(MAX_CHARS) : 16'hFFFF;

   function automatic logic [dwt_pkg::COUNT_W-1:0] sat_inc(
      input logic [dwt_pkg::COUNT_W-1:0] v);
      sat_inc = (v < SAT_LIMIT) ? v + 16'd1 : SAT_LIMIT;
   endfunction

   // configuration
   logic [2:0]                  delim_count_ff;
   logic [dwt_pkg::CHAR_W-1:0]  delim_ff [NREG];
   logic [dwt_pkg::COUNT_W-1:0] target_index_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_count_ff  <= 3'd0;
         target_index_ff <= 16'd1;
         for (int i = 0; i < NREG; i++) begin
            delim_ff[i] <= dwt_pkg::SPACE_CHAR;
         end
      end else if (csr_ch.valid) begin
         if (csr_ch.index == dwt_pkg::REG_DELIM_COUNT) begin
            delim_count_ff <= csr_ch.data[2:0];
         end
         if (csr_ch.index == dwt_pkg::REG_TARGET_INDEX) begin
            target_index_ff <= csr_ch.data;
         end
         for (int i = 0; i < NREG; i++) begin
            if (csr_ch.index == dwt_pkg::REG_DELIM_A + dwt_pkg::CSR_INDEX_W'(i)) begin
               delim_ff[i] <= csr_ch.data[dwt_pkg::CHAR_W-1:0];
            end
         end
      end
   end

   // input register
   logic                       in_valid_ff;
   logic [dwt_pkg::CHAR_W-1:0] char_ff;
   logic                       bvalid_ff;
   logic                       end_ff;

   logic rsp_valid_ff;
   logic out_free;
   logic advance;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && (!end_ff || out_free);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         char_ff   <= req_ch.char_byte;
         bvalid_ff <= req_ch.byte_valid;
         end_ff    <= req_ch.string_end;
      end
   end

   // per-string state
   logic [dwt_pkg::COUNT_W-1:0] pos_ff, words_ff, cur_start_ff, cur_len_ff;
   logic [dwt_pkg::COUNT_W-1:0] tbegin_ff, tlen_ff;
   logic                        inside_ff, hit_ff;

   logic [dwt_pkg::COUNT_W-1:0] pos_in, words_in, cur_start_in, cur_len_in;
   logic [dwt_pkg::COUNT_W-1:0] tbegin_in, tlen_in, words_inc, cur_len_inc;
   logic                        inside_in, hit_in;
   logic                        is_delim;

   dwt_delim_match #(
      .NUM_REGS (NREG)
   ) u_match (
      .char_byte   (char_ff),
      .delim_count (delim_count_ff),
      .delims      (delim_ff),
      .is_delim    (is_delim)
   );

   assign words_inc   = sat_inc(words_ff);
   assign cur_len_inc = sat_inc(cur_len_ff);

   always_comb begin
      pos_in       = pos_ff;
      words_in     = words_ff;
      cur_start_in = cur_start_ff;
      cur_len_in   = cur_len_ff;
      tbegin_in    = tbegin_ff;
      tlen_in      = tlen_ff;
      inside_in    = inside_ff;
      hit_in       = hit_ff;
      if (bvalid_ff) begin
         pos_in = sat_inc(pos_ff);
         if (is_delim) begin
            inside_in = 1'b0;
         end else if (!inside_ff) begin
            words_in     = words_inc;
            inside_in    = 1'b1;
            cur_start_in = pos_in;
            cur_len_in   = 16'd1;
            if (!hit_ff && (words_inc != words_ff) && (words_inc == target_index_ff)) begin
               hit_in    = 1'b1;
               tbegin_in = pos_in;
               tlen_in   = 16'd1;
            end
         end else begin
            cur_len_in = cur_len_inc;
            if (hit_ff && (words_ff == target_index_ff) && (cur_start_ff == tbegin_ff)) begin
               tlen_in = cur_len_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         words_ff     <= '0;
         cur_start_ff <= '0;
         cur_len_ff   <= '0;
         tbegin_ff    <= '0;
         tlen_ff      <= '0;
         inside_ff    <= 1'b0;
         hit_ff       <= 1'b0;
      end else if (advance) begin
         if (end_ff) begin
            pos_ff       <= '0;
            words_ff     <= '0;
            cur_start_ff <= '0;
            cur_len_ff   <= '0;
            tbegin_ff    <= '0;
            tlen_ff      <= '0;
            inside_ff    <= 1'b0;
            hit_ff       <= 1'b0;
         end else begin
            pos_ff       <= pos_in;
            words_ff     <= words_in;
            cur_start_ff <= cur_start_in;
            cur_len_ff   <= cur_len_in;
            tbegin_ff    <= tbegin_in;
            tlen_ff      <= tlen_in;
            inside_ff    <= inside_in;
            hit_ff       <= hit_in;
         end
      end
   end

   // result register
   logic [dwt_pkg::COUNT_W-1:0] word_total_ff, target_start_ff, target_length_ff;
   logic [dwt_pkg::COUNT_W-1:0] final_start_ff, final_length_ff;
   logic                        target_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && end_ff) begin
         word_total_ff     <= words_in;
         target_present_ff <= hit_in;
         target_start_ff   <= hit_in ? tbegin_in : '0;
         target_length_ff  <= hit_in ? tlen_in : '0;
         final_start_ff    <= (words_in != '0) ? cur_start_in : '0;
         final_length_ff   <= (words_in != '0) ? cur_len_in : '0;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.word_total     = word_total_ff;
   assign rsp_ch.target_present = target_present_ff;
   assign rsp_ch.target_start   = target_start_ff;
   assign rsp_ch.target_length  = target_length_ff;
   assign rsp_ch.final_start    = final_start_ff;
   assign rsp_ch.final_length   = final_length_ff;

endmodule

// ===== tb/dwt_checker.sv =====
// ----------------------------------------------------------------------------
// Tokenizer result checker
// Watches the configuration, input and result channels of the tokenizer.
// It keeps its own copy of the delimiter setup and per-string word state,
// builds the expected report for every closing item, and compares each
// result item field by field against the oldest outstanding report.
// ----------------------------------------------------------------------------
module dwt_checker #(
   parameter int unsigned MAX_CHARS   = 65535,
   parameter int          DELIM_SLOTS = 4
) (
   input  logic clock,
   input  logic reset,
   dwt_req_if   req_ch,
   dwt_rsp_if   rsp_ch,
   dwt_csr_if   csr_ch,
   output int   failures,
   output int   pending
);

   localparam int unsigned SAT_LIMIT    = (MAX_CHARS < 65535) ? MAX_CHARS : 65535;
   localparam int          ACTIVE_SLOTS = (DELIM_SLOTS < dwt_pkg::DELIM_REGS) ?
                                          DELIM_SLOTS : dwt_pkg::DELIM_REGS;

   typedef struct packed {
      logic [dwt_pkg::COUNT_W-1:0] word_total;
      logic                        target_present;
      logic [dwt_pkg::COUNT_W-1:0] target_start;
      logic [dwt_pkg::COUNT_W-1:0] target_length;
      logic [dwt_pkg::COUNT_W-1:0] final_start;
      logic [dwt_pkg::COUNT_W-1:0] final_length;
   } word_report_type;

   logic [2:0]                  delim_count;
   logic [dwt_pkg::CHAR_W-1:0]  delim_chars [dwt_pkg::DELIM_REGS];
   logic [dwt_pkg::COUNT_W-1:0] target_word;

   int unsigned char_pos;
   int unsigned words_so_far;
   int unsigned word_begin;
   int unsigned word_len;
   int unsigned target_pos;
   int unsigned target_len;
   bit          in_word;
   bit          target_found;

   word_report_type report_q [$];

   function automatic int unsigned sat_step(input int unsigned v);
      return (v < SAT_LIMIT) ? v + 1 : SAT_LIMIT;
   endfunction

   function automatic bit is_separator(input logic [dwt_pkg::CHAR_W-1:0] c);
      int n;
      n = delim_count;
      if (n == 0)
         return c == dwt_pkg::SPACE_CHAR;
      if (n > ACTIVE_SLOTS)
         n = ACTIVE_SLOTS;
      for (int i = 0; i < n; i++)
         if (delim_chars[i] == c)
            return 1'b1;
      return 1'b0;
   endfunction

   task automatic clear_string();
      char_pos     = 0;
      in_word      = 1'b0;
      words_so_far = 0;
      word_begin   = 0;
      word_len     = 0;
      target_found = 1'b0;
      target_pos   = 0;
      target_len   = 0;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      word_report_type want;
      int unsigned     prior;
      if (reset) begin
         delim_count = '0;
         foreach (delim_chars[i])
            delim_chars[i] = dwt_pkg::SPACE_CHAR;
         target_word = 1;
         clear_string();
         report_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == dwt_pkg::REG_DELIM_COUNT)
               delim_count = csr_ch.data[2:0];
            else if (csr_ch.index >= dwt_pkg::REG_DELIM_A &&
                     csr_ch.index < dwt_pkg::REG_DELIM_A + dwt_pkg::DELIM_REGS)
               delim_chars[csr_ch.index - dwt_pkg::REG_DELIM_A] =
                  csr_ch.data[dwt_pkg::CHAR_W-1:0];
            else if (csr_ch.index == dwt_pkg::REG_TARGET_INDEX)
               target_word = csr_ch.data;
         end

         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.byte_valid) begin
               char_pos = sat_step(char_pos);
               if (is_separator(req_ch.char_byte)) begin
                  in_word = 1'b0;
               end else if (!in_word) begin
                  prior        = words_so_far;
                  words_so_far = sat_step(words_so_far);
                  in_word      = 1'b1;
                  word_begin   = char_pos;
                  word_len     = 1;
                  if (!target_found && words_so_far != prior &&
                      words_so_far == target_word) begin
                     target_found = 1'b1;
                     target_pos   = char_pos;
                     target_len   = 1;
                  end
               end else begin
                  word_len = sat_step(word_len);
                  if (target_found && words_so_far == target_word &&
                      word_begin == target_pos)
                     target_len = word_len;
               end
            end
            if (req_ch.string_end) begin
               want.word_total     = dwt_pkg::COUNT_W'(words_so_far);
               want.target_present = target_found;
               want.target_start   = target_found ? dwt_pkg::COUNT_W'(target_pos) : '0;
               want.target_length  = target_found ? dwt_pkg::COUNT_W'(target_len) : '0;
               want.final_start    = (words_so_far != 0) ?
                                     dwt_pkg::COUNT_W'(word_begin) : '0;
               want.final_length   = (words_so_far != 0) ?
                                     dwt_pkg::COUNT_W'(word_len) : '0;
               report_q.push_back(want);
               clear_string();
            end
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            if (report_q.size() == 0) begin
               $error("result item with no report outstanding: word_total %0d",
                      rsp_ch.word_total);
               failures++;
            end else begin
               want = report_q.pop_front();
               check_field("word_total", want.word_total, rsp_ch.word_total);
               check_field("target_present", want.target_present, rsp_ch.target_present);
               check_field("target_start", want.target_start, rsp_ch.target_start);
               check_field("target_length", want.target_length, rsp_ch.target_length);
               check_field("final_start", want.final_start, rsp_ch.final_start);
               check_field("final_length", want.final_length, rsp_ch.final_length);
            end
         end
      end
      pending = report_q.size();
   end

endmodule

// ===== tb/delimited_word_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// Delimited word tokenizer testbench
// Drives strings through the tokenizer under several delimiter and target
// settings: a directed set of corner strings, then random strings with
// random sender gaps and receiver stalls, including long result back-pressure.
// Checking is done by the report checker instantiated beside the block.
// ----------------------------------------------------------------------------
module delimited_word_tokenizer_tb;

   localparam int unsigned MAX_CHARS     = 65535;
   localparam int          DELIM_SLOTS   = 4;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_ITEMS   = 60;
   localparam int          HOLD_CYCLES   = 300;

   typedef logic [dwt_pkg::CHAR_W-1:0] byte_q_type [$];

   logic clock;
   logic reset;
   int   failures;
   int   pending;

   bit   req_steady;
   bit   rsp_steady;

   logic [2:0]                 cur_count;
   logic [dwt_pkg::CHAR_W-1:0] cur_delims [dwt_pkg::DELIM_REGS];
   byte_q_type                 msg;

   dwt_req_if req_ch ();
   dwt_rsp_if rsp_ch ();
   dwt_csr_if csr_ch ();

   delimited_word_tokenizer #(
      .MAX_CHARS   (MAX_CHARS),
      .DELIM_SLOTS (DELIM_SLOTS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   dwt_checker #(
      .MAX_CHARS   (MAX_CHARS),
      .DELIM_SLOTS (DELIM_SLOTS)
   ) report_checker (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_ch   (csr_ch),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic push_char(input logic [dwt_pkg::CHAR_W-1:0] ch, input logic has_byte,
                            input logic closes);
      int gap;
      if ($urandom_range(0, 15) == 0)
         req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.char_byte  <= ch;
      req_ch.byte_valid <= has_byte;
      req_ch.string_end <= closes;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_bytes(input byte_q_type text, input bit bare_end);
      foreach (text[i])
         push_char(text[i], 1'b1, !bare_end && i == text.size() - 1);
      if (bare_end)
         push_char(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic csr_write(input logic [dwt_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dwt_pkg::CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic set_config(input logic [2:0] count,
                             input logic [dwt_pkg::CHAR_W-1:0] a,
                             input logic [dwt_pkg::CHAR_W-1:0] b,
                             input logic [dwt_pkg::CHAR_W-1:0] c,
                             input logic [dwt_pkg::CHAR_W-1:0] d,
                             input logic [dwt_pkg::COUNT_W-1:0] tgt);
      logic [dwt_pkg::CHAR_W-1:0]     chars [dwt_pkg::DELIM_REGS];
      logic [dwt_pkg::CSR_DATA_W-1:0] noise;
      chars     = '{a, b, c, d};
      cur_count = count;
      noise     = $urandom;
      csr_write(dwt_pkg::REG_DELIM_COUNT, {noise[dwt_pkg::CSR_DATA_W-1:3], count});
      for (int i = 0; i < dwt_pkg::DELIM_REGS; i++) begin
         cur_delims[i] = chars[i];
         noise         = $urandom;
         csr_write(dwt_pkg::REG_DELIM_A + dwt_pkg::CSR_INDEX_W'(i),
                   {noise[dwt_pkg::CSR_DATA_W-1:dwt_pkg::CHAR_W], chars[i]});
      end
      csr_write(dwt_pkg::REG_TARGET_INDEX, tgt);
      // unmapped index, must be dropped
      csr_write(dwt_pkg::CSR_INDEX_W'($urandom_range(dwt_pkg::REG_TARGET_INDEX + 1,
                                                     2**dwt_pkg::CSR_INDEX_W - 1)),
                16'($urandom));
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [dwt_pkg::CHAR_W-1:0] pick_char();
      int n;
      n = (cur_count > DELIM_SLOTS) ? DELIM_SLOTS : cur_count;
      case ($urandom_range(0, 5))
         0:       return 8'($urandom);
         1, 2:    return (n == 0) ? dwt_pkg::SPACE_CHAR : cur_delims[$urandom_range(0, n - 1)];
         3:       return dwt_pkg::SPACE_CHAR;
         default: return 8'("a" + $urandom_range(0, 3));
      endcase
   endfunction

   task automatic send_random_string(output int sent);
      int len;
      bit bare;
      len  = $urandom_range(0, 12);
      bare = (len == 0) || ($urandom_range(0, 3) == 0);
      sent = 0;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            push_char(8'($urandom), 1'b0, 1'b0);
            sent++;
         end
         push_char(pick_char(), 1'b1, !bare && i == len - 1);
         sent++;
      end
      if (bare) begin
         push_char(8'($urandom), 1'b0, 1'b1);
         sent++;
      end
   endtask

   // result side: random stalls, with a long hold every 25 items
   initial begin
      int stall;
      int taken;
      taken        = 0;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, 4);
         if (taken % 25 == 24)
            stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   initial begin
      int                          items;
      int                          sent;
      logic [dwt_pkg::COUNT_W-1:0] tgt;
      logic [dwt_pkg::CHAR_W-1:0]  da;
      logic [dwt_pkg::CHAR_W-1:0]  db;

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.char_byte  <= '0;
      req_ch.byte_valid <= 1'b0;
      req_ch.string_end <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= '0;
      csr_ch.data       <= '0;
      cur_count         = '0;
      foreach (cur_delims[i])
         cur_delims[i] = dwt_pkg::SPACE_CHAR;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: space only, first word
      msg.delete();
      send_bytes(msg, 1'b1);
      msg = {" ", "h", "i", " ", " ", "y", "o"};
      send_bytes(msg, 1'b0);

      // zero byte and 0xff as delimiters, space ordinary
      drain();
      set_config(3'd2, 8'h00, 8'hFF, "x", "y", 16'd2);
      msg = {8'h00, "A", 8'hFF, " ", "B", 8'h00};
      send_bytes(msg, 1'b1);

      // count above the slot number, target zero
      drain();
      set_config(3'd7, "x", "y", "z", "w", 16'd0);
      msg = {"a", "x", "b", "y", "c", "z", "d", "w", "e"};
      send_bytes(msg, 1'b0);

      // one delimiter in use, target past the last word
      drain();
      set_config(3'd1, "x", "y", "z", "w", 16'd5);
      msg = {"a", "x", "b", "y"};
      send_bytes(msg, 1'b1);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         case ($urandom_range(0, 3))
            0:       tgt = '0;
            default: tgt = 16'($urandom_range(1, 4));
         endcase
         if (phase == 1)
            tgt = 16'd32768;
         else if (phase == 2)
            tgt = 16'hFFFF;
         da = (phase == 3) ? 8'h00 : 8'($urandom);
         db = (phase == 3) ? 8'hFF : 8'($urandom);
         set_config(3'(phase), da, db, 8'($urandom), 8'($urandom), tgt);
         items = 0;
         while (items < PHASE_ITEMS) begin
            send_random_string(sent);
            items += sent;
         end
      end
      drain();

      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== delimited_word_tokenizer.f =====
src/dwt_pkg.sv
src/dwt_req_if.sv
src/dwt_rsp_if.sv
src/dwt_csr_if.sv
src/dwt_delim_match.sv
src/delimited_word_tokenizer.sv
tb/dwt_checker.sv
tb/delimited_word_tokenizer_tb.sv
